// File: hdl/mbps_pkg.sv
package mbps_pkg;

   // Pattern store and scan window depth
   localparam int PAT_DEPTH = 64;
   localparam int IDX_W     = 6;
   localparam int LEN_W     = 7;
   localparam int OFS_W     = 32;

   // Item kinds
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_SCAN = 1'b1;

   // Register indexes
   localparam logic CSR_PATTERN_LENGTH = 1'b0;
   localparam logic CSR_START_OFFSET   = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic fetch;
      logic step;
      logic set_match;
      logic finish;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_scan;
      logic need_cmp;
      logic entry_ok;
      logic last_entry;
      logic out_free;
      logic has_result;
   } dp_status_type;

   // Bring the configured length into 1 .. PAT_DEPTH
   function automatic logic [LEN_W-1:0] clamp_length(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] res;
      res = len;
      if (len == '0) begin
         res = LEN_W'(1);
      end else if (len > LEN_W'(PAT_DEPTH)) begin
         res = LEN_W'(PAT_DEPTH);
      end
      return res;
   endfunction

endpackage

// File: hdl/mbps_datapath.sv
module mbps_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  mbps_pkg::dp_cmd_type        cmd,
   output mbps_pkg::dp_status_type     status,
   input  logic                        req_func,
   input  logic [5:0]                  req_entry_index,
   input  logic [7:0]                  req_value,
   input  logic                        req_care,
   input  logic                        req_last,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [31:0]                 csr_wdata,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [31:0]                 rsp_match_offset
);
   import mbps_pkg::*;

   // Pattern store (care bit over byte) and circular scan window
   logic [8:0]       pat_mem [PAT_DEPTH];
   logic [7:0]       win_mem [PAT_DEPTH];

   logic [LEN_W-1:0] pat_len_ff, pat_len_in;
   logic [OFS_W-1:0] start_ff, start_in;
   logic [IDX_W-1:0] wptr_ff, wptr_in;
   logic [OFS_W-1:0] seen_ff, seen_in;
   logic             finished_ff, finished_in;
   logic             last_ff, last_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             match_ff, match_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] waddr_ff, waddr_in;
   logic [8:0]       pat_rd_ff;
   logic [7:0]       win_rd_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [OFS_W-1:0] rsp_ofs_ff, rsp_ofs_in;

   logic [LEN_W-1:0] len_now;
   logic [OFS_W-1:0] match_ofs;

   assign len_now   = clamp_length(pat_len_ff);
   assign match_ofs = start_ff + seen_ff - OFS_W'(len_ff);

   // Status towards the controller
   always_comb begin
      status.is_scan    = (req_func == FUNC_SCAN);
      status.need_cmp   = !finished_ff && (seen_ff >= OFS_W'(len_ff));
      status.entry_ok   = !pat_rd_ff[8] || (pat_rd_ff[7:0] == win_rd_ff);
      status.last_entry = ({1'b0, idx_ff} == (len_ff - LEN_W'(1)));
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.has_result = match_ff || (last_ff && !finished_ff);
   end

   // Memory writes and registered reads
   always_ff @(posedge clock) begin
      if (cmd.take && req_func == FUNC_LOAD) begin
         pat_mem[req_entry_index] <= {req_care, req_value};
      end
      if (cmd.take && req_func == FUNC_SCAN && !finished_ff) begin
         win_mem[wptr_ff] <= req_value;
      end
      if (cmd.fetch) begin
         pat_rd_ff <= pat_mem[idx_ff];
         win_rd_ff <= win_mem[waddr_ff];
      end
   end

   // Next-state logic
   always_comb begin
      pat_len_in   = pat_len_ff;
      start_in     = start_ff;
      wptr_in      = wptr_ff;
      seen_in      = seen_ff;
      finished_in  = finished_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      match_in     = match_ff;
      idx_in       = idx_ff;
      waddr_in     = waddr_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ofs_in   = rsp_ofs_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // Register writes
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: pat_len_in = csr_wdata[LEN_W-1:0];
            CSR_START_OFFSET:   start_in   = csr_wdata;
            default:            pat_len_in = pat_len_ff;
         endcase
      end

      // Take a scan byte: unless already finished, write it into the window and advance the count
      if (cmd.take && req_func == FUNC_SCAN) begin
         last_in  = req_last;
         len_in   = len_now;
         match_in = 1'b0;
         idx_in   = '0;
         waddr_in = IDX_W'(wptr_ff + IDX_W'(1) - len_now[IDX_W-1:0]);
         if (!finished_ff) begin
            wptr_in = IDX_W'(wptr_ff + IDX_W'(1));
            if (seen_ff != '1) begin
               seen_in = seen_ff + OFS_W'(1);
            end
         end
      end

      // Walk the compare along the window
      if (cmd.step) begin
         idx_in   = IDX_W'(idx_ff + IDX_W'(1));
         waddr_in = IDX_W'(waddr_ff + IDX_W'(1));
      end
      if (cmd.set_match) begin
         match_in = 1'b1;
      end

      // Deliver the result, finish the scan on a match, and close it on its last byte
      if (cmd.finish) begin
         if (status.has_result) begin
            rsp_valid_in = 1'b1;
            rsp_found_in = match_ff;
            rsp_ofs_in   = match_ff ? match_ofs : '0;
         end
         if (last_ff) begin
            seen_in     = '0;
            finished_in = 1'b0;
         end else if (match_ff) begin
            finished_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff   <= LEN_W'(1);
         start_ff     <= '0;
         wptr_ff      <= '0;
         seen_ff      <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_len_ff   <= pat_len_in;
         start_ff     <= start_in;
         wptr_ff      <= wptr_in;
         seen_ff      <= seen_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      len_ff       <= len_in;
      match_ff     <= match_in;
      idx_ff       <= idx_in;
      waddr_ff     <= waddr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ofs_ff   <= rsp_ofs_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_ofs_ff;

endmodule

// File: hdl/mbps_ctrl.sv
module mbps_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  mbps_pkg::dp_status_type     status,
   output mbps_pkg::dp_cmd_type        cmd
);
   import mbps_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PREP   = 5'b00010,
      ST_FETCH  = 5'b00100,
      ST_CHECK  = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Sequence one item: take it; for a scan byte, compare entry by entry, report
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.is_scan) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            state_in = status.need_cmp ? ST_FETCH : ST_REPORT;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (!status.entry_ok) begin
               state_in = ST_REPORT;
            end else if (status.last_entry) begin
               cmd.set_match = 1'b1;
               state_in      = ST_REPORT;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_REPORT: begin
            // Hold while a result waits for a full output register
            if (!status.has_result || status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/masked_byte_pattern_scanner.sv
// Pattern load: the next item is taken in the following cycle.
// Scan byte: from transfer to ready again the controller runs prepare, one
// fetch/check pair per entry compared (at most the pattern length), through
// the single read port of the pattern store and of the window memory, then report.
// The result is registered as ready returns; one still waiting stalls the report.
// Synchronous active-high reset clears scan state, offset, rsp_valid; length 1.
module masked_byte_pattern_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [5:0]  req_entry_index,
   input  logic [7:0]  req_value,
   input  logic        req_care,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_match_offset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import mbps_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mbps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbps_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_func),
      .req_entry_index  (req_entry_index),
      .req_value        (req_value),
      .req_care         (req_care),
      .req_last         (req_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset)
   );

endmodule

// File: hdl/mbps_checker.sv
module mbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_func,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [31:0] rsp_match_offset
);

   // A result waiting for transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
                                   && $stable(rsp_match_offset))
      else $error("result changed before transfer");

   // A not-found result carries a zero offset
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == 32'd0)
      else $error("not-found result with non-zero offset");

   // A new result is only loaded while the input side is busy with a scan byte
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while input side was idle");

   // No result straight out of reset
   a_rst_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_func         (req_func),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_found        (rsp_found),
   .rsp_match_offset (rsp_match_offset)
);

// File: tb/mbps_report_checker.sv
`timescale 1ns / 100ps

module mbps_report_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [5:0]  req_entry_index,
   input  logic [7:0]  req_value,
   input  logic        req_care,
   input  logic        req_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_found,
   input  logic [31:0] rsp_match_offset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          reports_due,
   output int          live_items,
   output int          hits_seen,
   output int          misses_seen
);
   import mbps_pkg::*;

   typedef struct packed {
      logic        found;
      logic [31:0] offset;
   } report_type;

   // Expected scan reports, oldest first
   report_type       due_reports[$];
   report_type       want;
   report_type       fresh;
   logic             fresh_valid;

   // Own copy of the scanner state and registers
   logic [7:0]       pat_value[PAT_DEPTH];
   logic             pat_care[PAT_DEPTH];
   logic [7:0]       history[PAT_DEPTH];
   logic [31:0]      scanned;
   logic             matched;
   logic [LEN_W-1:0] cfg_length;
   logic [31:0]      cfg_offset;

   // Push one scan byte through the window and work out its report, if any
   task automatic advance_scan(input logic [7:0] b, input logic last_b,
                               output logic produced, output report_type rep);
      int  n;
      int  i;
      int  k;
      logic hit;
      produced = 1'b0;
      rep      = '0;
      if (!matched) begin
         n = int'(cfg_length);
         if (n < 1) begin
            n = 1;
         end else if (n > PAT_DEPTH) begin
            n = PAT_DEPTH;
         end
         for (k = PAT_DEPTH - 1; k > 0; k--) begin
            history[k] = history[k - 1];
         end
         history[0] = b;
         if (scanned != '1) begin
            scanned++;
         end
         hit = (scanned >= 32'(n));
         for (i = 0; i < n; i++) begin
            if (pat_care[i] && pat_value[i] != history[n - 1 - i]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            matched    = 1'b1;
            rep.found  = 1'b1;
            rep.offset = cfg_offset + scanned - 32'(n);
            produced   = 1'b1;
         end else if (last_b) begin
            produced = 1'b1;
         end
      end
      // Close the scan on its final byte
      if (last_b) begin
         for (k = 0; k < PAT_DEPTH; k++) begin
            history[k] = '0;
         end
         scanned = '0;
         matched = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAT_DEPTH; i++) begin
            pat_value[i] = '0;
            pat_care[i]  = 1'b0;
            history[i]   = '0;
         end
         scanned     = '0;
         matched     = 1'b0;
         cfg_length  = LEN_W'(1);
         cfg_offset  = '0;
         due_reports.delete();
         fail_count  = 0;
         live_items  = 0;
         hits_seen   = 0;
         misses_seen = 0;
      end else begin
         // Compare a result transfer with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (due_reports.size() == 0) begin
               $error("unexpected result: found %0b match_offset %h",
                      rsp_found, rsp_match_offset);
               fail_count++;
            end else begin
               want = due_reports.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0b, actual %0b", want.found, rsp_found);
                  fail_count++;
               end
               if (rsp_match_offset !== want.offset) begin
                  $error("match_offset: expected %h, actual %h",
                         want.offset, rsp_match_offset);
                  fail_count++;
               end
            end
         end

         // Track register writes
         if (csr_wr_en) begin
            if (csr_index == CSR_PATTERN_LENGTH) begin
               cfg_length = csr_wdata[LEN_W-1:0];
            end else begin
               cfg_offset = csr_wdata;
            end
         end

         // Predict from each accepted request transfer
         if (req_valid && req_ready) begin
            live_items++;
            if (req_func == FUNC_LOAD) begin
               pat_value[req_entry_index] = req_value;
               pat_care[req_entry_index]  = req_care;
            end else begin
               advance_scan(req_value, req_last, fresh_valid, fresh);
               if (fresh_valid) begin
                  due_reports.push_back(fresh);
                  if (fresh.found) begin
                     hits_seen++;
                  end else begin
                     misses_seen++;
                  end
               end
            end
         end
      end
      reports_due = due_reports.size();
   end

endmodule

// File: tb/tb_masked_byte_pattern_scanner.sv
`timescale 1ns / 100ps

module tb_masked_byte_pattern_scanner;
   import mbps_pkg::*;

   localparam int ITEM_GOAL   = 1350;
   localparam int STALL_LIMIT = 2000;
   // Longest scan byte, with all PAT_DEPTH entries compared, plus margin
   localparam int HOLD_OFF    = 140;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic        req_func        = FUNC_LOAD;
   logic [5:0]  req_entry_index = '0;
   logic [7:0]  req_value       = '0;
   logic        req_care        = 1'b0;
   logic        req_last        = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic        rsp_found;
   logic [31:0] rsp_match_offset;
   logic        csr_wr_en       = 1'b0;
   logic        csr_index       = CSR_PATTERN_LENGTH;
   logic [31:0] csr_wdata       = '0;

   int fail_count;
   int reports_due;
   int live_items;
   int hits_seen;
   int misses_seen;

   // Sender and receiver pacing
   int burst_left  = 0;
   bit no_gaps     = 1'b0;
   int rx_mode     = 0;
   int rx_mode_left = 0;
   int rx_run      = 0;
   bit rx_low      = 1'b0;
   int idle_cycles = 0;
   int phases      = 0;

   // Pattern as loaded into the block, used to plant matches
   logic [7:0] pat_val[PAT_DEPTH];
   logic       pat_on[PAT_DEPTH];
   int         pat_len = 1;

   masked_byte_pattern_scanner dut (.*);

   mbps_report_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_entry_index  (req_entry_index),
      .req_value        (req_value),
      .req_care         (req_care),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .reports_due      (reports_due),
      .live_items       (live_items),
      .hits_seen        (hits_seen),
      .misses_seen      (misses_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: always ready, random stalls, or long stall runs
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = $urandom_range(0, 2);
         rx_mode_left = $urandom_range(20, 200);
      end else begin
         rx_mode_left--;
      end
      case (rx_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            if (rx_run == 0) begin
               rx_low = !rx_low;
               rx_run = rx_low ? $urandom_range(1, 25) : $urandom_range(1, 4);
            end else begin
               rx_run--;
            end
            rsp_ready <= !rx_low;
         end
      endcase
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // Offer one request and hold it until the transfer; bursts with gaps between
   task automatic put_item(input logic func, input logic [5:0] idx, input logic [7:0] val,
                           input logic care, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = no_gaps ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_func        <= func;
      req_entry_index <= idx;
      req_value       <= val;
      req_care        <= care;
      req_last        <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic load_entry(input logic [5:0] idx, input logic [7:0] val, input logic on);
      pat_val[idx] = val;
      pat_on[idx]  = on;
      put_item(FUNC_LOAD, idx, val, on, 1'($urandom));
   endtask

   task automatic scan_byte(input logic [7:0] val, input logic last);
      put_item(FUNC_SCAN, 6'($urandom), val, 1'($urandom), last);
   endtask

   // Drop valid, wait for every expected result, then let the block drain
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (reports_due == 0);
      repeat (HOLD_OFF) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Background byte: often one of the pattern bytes so near-misses are common
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 1) == 1) begin
         return pat_val[$urandom_range(0, pat_len - 1)];
      end
      return 8'($urandom);
   endfunction

   task automatic load_pattern(input int care_pct);
      int i;
      for (i = 0; i < pat_len; i++) begin
         load_entry(6'(i), 8'($urandom), $urandom_range(0, 99) < care_pct);
      end
   endtask

   // One scan of span bytes, optionally with the pattern planted inside
   task automatic run_scan(input int span, input bit plant);
      int at;
      int pos;
      int rel;
      logic [7:0] b;
      at = -1;
      if (plant && span >= pat_len) begin
         at = int'($urandom_range(0, span - pat_len));
      end
      for (pos = 0; pos < span; pos++) begin
         // Occasional pattern load in the middle of a scan
         if ($urandom_range(0, 99) < 4) begin
            load_entry(6'($urandom), 8'($urandom), 1'($urandom));
         end
         rel = pos - at;
         if (at >= 0 && rel >= 0 && rel < pat_len) begin
            b = pat_on[rel] ? pat_val[rel] : 8'($urandom);
            // Break the planted copy now and then
            if ($urandom_range(0, 19) == 0) begin
               b = b ^ (8'd1 << $urandom_range(0, 7));
            end
         end else begin
            b = pick_byte();
         end
         scan_byte(b, pos == span - 1);
      end
   endtask

   initial begin
      int r;
      int len_code;
      int span;
      int i;
      logic [31:0] ofs;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Fill the whole pattern store so no unwritten entry is ever compared
      for (i = 0; i < PAT_DEPTH; i++) begin
         load_entry(6'(i), 8'($urandom), 1'($urandom));
      end

      // Single-byte pattern: match mid-scan, ignored tail, a miss, match on last byte
      settle();
      write_reg(CSR_PATTERN_LENGTH, 32'd1);
      write_reg(CSR_START_OFFSET, 32'd0);
      load_entry(6'd0, 8'hAB, 1'b1);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'hFF, 1'b0);
      scan_byte(8'hAB, 1'b0);
      scan_byte(8'hAB, 1'b0);
      scan_byte(8'h12, 1'b1);
      scan_byte(8'h55, 1'b1);
      scan_byte(8'hAB, 1'b1);
      // Wildcard entry matches anything
      load_entry(6'd0, 8'hFF, 1'b0);
      scan_byte(8'h00, 1'b1);

      // Zero length treated as one, offset at the top of the range
      settle();
      write_reg(CSR_PATTERN_LENGTH, 32'd0);
      write_reg(CSR_START_OFFSET, 32'hFFFF_FFFF);
      scan_byte(8'h3C, 1'b1);

      // Three entries with a wildcard: too few bytes, cleared window, wrapping offset
      settle();
      write_reg(CSR_PATTERN_LENGTH, 32'd3);
      write_reg(CSR_START_OFFSET, 32'hFFFF_FFFE);
      load_entry(6'd0, 8'h01, 1'b1);
      load_entry(6'd1, 8'hFF, 1'b0);
      load_entry(6'd2, 8'h03, 1'b1);
      load_entry(6'd63, 8'h00, 1'b1);
      scan_byte(8'h01, 1'b0);
      scan_byte(8'h02, 1'b1);
      scan_byte(8'h03, 1'b1);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'h00, 1'b0);
      scan_byte(8'h01, 1'b0);
      scan_byte(8'h55, 1'b0);
      scan_byte(8'h03, 1'b1);

      // Random phases: new registers and pattern, then a few scans each
      while (live_items < ITEM_GOAL) begin
         settle();
         phases++;
         r = $urandom_range(0, 99);
         if (r < 55) begin
            len_code = $urandom_range(1, 6);
         end else if (r < 80) begin
            len_code = $urandom_range(7, 20);
         end else if (r < 90) begin
            len_code = $urandom_range(21, 63);
         end else if (r < 94) begin
            len_code = PAT_DEPTH;
         end else if (r < 97) begin
            len_code = $urandom_range(PAT_DEPTH + 1, 127);
         end else begin
            len_code = 0;
         end
         pat_len = (len_code < 1) ? 1 : (len_code > PAT_DEPTH) ? PAT_DEPTH : len_code;

         r = $urandom_range(0, 99);
         if (r < 30) begin
            ofs = '0;
         end else if (r < 50) begin
            ofs = 32'hFFFF_FFFF - $urandom_range(0, 40);
         end else begin
            ofs = $urandom;
         end
         // Upper bits of the length write are junk that the register drops
         write_reg(CSR_PATTERN_LENGTH, {25'($urandom), 7'(len_code)});
         write_reg(CSR_START_OFFSET, ofs);
         no_gaps = ($urandom_range(0, 3) == 0);
         load_pattern($urandom_range(50, 100));

         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 99) < 15) begin
               span = $urandom_range(1, pat_len);
            end else begin
               span = pat_len + $urandom_range(0, (pat_len < 8) ? 24 : 16);
            end
            run_scan(span, $urandom_range(0, 9) < 7);
         end
      end

      settle();
      $display("Covered %0d items over %0d random phases:", live_items, phases);
      $display("%0d scans matched, %0d ended unmatched.", hits_seen, misses_seen);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/mbps_pkg.sv
hdl/mbps_datapath.sv
hdl/mbps_ctrl.sv
hdl/masked_byte_pattern_scanner.sv
hdl/mbps_checker.sv
tb/mbps_report_checker.sv
tb/tb_masked_byte_pattern_scanner.sv
